// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vmc8_pkg.sv -----
// Package: sizes, font table, address wrap and ALU types for the interpreter core.
`timescale 1ns / 1ps

package vmc8_pkg;

    localparam int MEMORY_BYTES   = 4096;
    localparam int DISPLAY_PIXELS = 2048;
    localparam int DISPLAY_WIDTH  = 64;
    localparam int STACK_DEPTH    = 16;
    localparam int PROGRAM_START  = 512;

    localparam int MEM_AW     = $clog2(MEMORY_BYTES);
    localparam int FB_BYTES   = DISPLAY_PIXELS / 8;
    localparam int FB_AW      = $clog2(FB_BYTES);
    localparam int SP_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W      = $clog2(MEMORY_BYTES);
    localparam int FONT_BYTES = 80;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // shared ALU operations
    localparam logic [2:0] ALU_PASS = 3'd0;
    localparam logic [2:0] ALU_OR   = 3'd1;
    localparam logic [2:0] ALU_AND  = 3'd2;
    localparam logic [2:0] ALU_XOR  = 3'd3;
    localparam logic [2:0] ALU_ADD  = 3'd4;
    localparam logic [2:0] ALU_SUB  = 3'd5;
    localparam logic [2:0] ALU_SHR  = 3'd6;
    localparam logic [2:0] ALU_SHL  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } alu_rsp_t;

    // reset content of main memory
    function automatic logic [7:0] font_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] val;
        val = 8'h00;
        if (idx < CNT_W'(FONT_BYTES))
            val = FONT[idx[6:0]];
        return val;
    endfunction

    // 12-bit address modulo MEMORY_BYTES (at least 1024, so three folds suffice)
    function automatic logic [MEM_AW-1:0] mem_index(input logic [11:0] a);
        logic [12:0] t;
        t = {1'b0, a};
        for (int k = 0; k < 3; k++)
        begin
            if (t >= 13'(MEMORY_BYTES))
                t = t - 13'(MEMORY_BYTES);
        end
        return t[MEM_AW-1:0];
    endfunction

endpackage

// ----- hdl/vm_core_8bit_sixteen_register.sv -----
// Top level: sequencer, architectural state and memories of the interpreter core.
`timescale 1ns / 1ps

// Channel  Handshake            Word
// -------  -------------------  ---------------------------------------------------
// in       in_valid / in_stall  mode, address, data, keys, random_byte
// out      out_valid/out_stall  program_counter, executed_opcode, display_changed,
//                               sound_on, waiting_for_key, invalid_opcode, display_byte
//
// After reset a sweep writes the font and zeros into main memory and clears the
// frame buffer, with in_stall high. A load or unknown-mode word goes straight to the
// output register, a read word reads the frame buffer first, and an instruction
// is fetched, reads its registers, executes and ticks the timers. 8XY4..8XYE add
// a flag write, 00E0 clears the frame buffer byte by byte, DXYN reads and rewrites
// two frame buffer bytes per sprite row and then VF, FX55/FX65 move one register
// at a time and FX33 writes three digits. Main memory and the frame buffer are
// single-port RAMs, which serialises these steps. in_stall is low only in idle; a
// finished word sits in the output register while the next input word is taken.

module vm_core_8bit_sixteen_register import vmc8_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] program_counter,
    output logic [15:0] executed_opcode,
    output logic        display_changed,
    output logic        sound_on,
    output logic        waiting_for_key,
    output logic        invalid_opcode,
    output logic [7:0]  display_byte
);

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_RD    = 5'd3;
    localparam logic [4:0] S_F1    = 5'd4;
    localparam logic [4:0] S_F2    = 5'd5;
    localparam logic [4:0] S_VX    = 5'd6;
    localparam logic [4:0] S_VY    = 5'd7;
    localparam logic [4:0] S_EXEC  = 5'd8;
    localparam logic [4:0] S_WRF   = 5'd9;
    localparam logic [4:0] S_CLS   = 5'd10;
    localparam logic [4:0] S_DMEM  = 5'd11;
    localparam logic [4:0] S_DFB0R = 5'd12;
    localparam logic [4:0] S_DFB0W = 5'd13;
    localparam logic [4:0] S_DFB1R = 5'd14;
    localparam logic [4:0] S_DFB1W = 5'd15;
    localparam logic [4:0] S_DVF   = 5'd16;
    localparam logic [4:0] S_BCD1  = 5'd17;
    localparam logic [4:0] S_BCD2  = 5'd18;
    localparam logic [4:0] S_SVR   = 5'd19;
    localparam logic [4:0] S_SMW   = 5'd20;
    localparam logic [4:0] S_LMR   = 5'd21;
    localparam logic [4:0] S_LVW   = 5'd22;
    localparam logic [4:0] S_TICK  = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // instruction classes (top nibble)
    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEI  = 4'h3;
    localparam logic [3:0] OPC_SNEI = 4'h4;
    localparam logic [3:0] OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LDI  = 4'h6;
    localparam logic [3:0] OPC_ADDI = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9;
    localparam logic [3:0] OPC_LDIX = 4'hA;
    localparam logic [3:0] OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_DRW  = 4'hD;
    localparam logic [3:0] OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // 8XYn sub-ops
    localparam logic [3:0] AOP_LD   = 4'h0;
    localparam logic [3:0] AOP_OR   = 4'h1;
    localparam logic [3:0] AOP_AND  = 4'h2;
    localparam logic [3:0] AOP_XOR  = 4'h3;
    localparam logic [3:0] AOP_ADD  = 4'h4;
    localparam logic [3:0] AOP_SUB  = 4'h5;
    localparam logic [3:0] AOP_SHR  = 4'h6;
    localparam logic [3:0] AOP_SUBN = 4'h7;
    localparam logic [3:0] AOP_SHL  = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    // FXnn sub-ops
    localparam logic [7:0] FOP_GDT  = 8'h07;
    localparam logic [7:0] FOP_WKEY = 8'h0A;
    localparam logic [7:0] FOP_SDT  = 8'h15;
    localparam logic [7:0] FOP_SST  = 8'h18;
    localparam logic [7:0] FOP_ADDI = 8'h1E;
    localparam logic [7:0] FOP_FONT = 8'h29;
    localparam logic [7:0] FOP_BCD  = 8'h33;
    localparam logic [7:0] FOP_STOR = 8'h55;
    localparam logic [7:0] FOP_LOAD = 8'h65;

    localparam logic [3:0] REG_F = 4'hF;

    // sequencer and latched input word
    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       mode_reg, mode_next;
    logic [11:0]      addr_reg, addr_next;
    logic [7:0]       data_reg, data_next;
    logic [15:0]      keys_reg, keys_next;
    logic [7:0]       rnd_reg, rnd_next;

    // architectural state
    logic [11:0]      pc_reg, pc_next;
    logic [11:0]      i_reg, i_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [7:0]       delay_reg, delay_next;
    logic [7:0]       sound_reg, sound_next;
    logic [7:0]       v_reg [16];
    logic [11:0]      stack_reg [STACK_DEPTH];

    // per-instruction working registers
    logic [15:0]      op_reg, op_next;
    logic [7:0]       vx_reg, vx_next;
    logic [7:0]       vy_reg, vy_next;
    logic             flag_reg, flag_next;
    logic             hit_reg, hit_next;
    logic [7:0]       sprite_reg, sprite_next;
    logic [3:0]       row_reg, row_next;
    logic             drew_reg, drew_next;
    logic             wait_reg, wait_next;
    logic             bad_reg, bad_next;
    logic [7:0]       dbyte_reg, dbyte_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [11:0]      out_pc_reg;
    logic [15:0]      out_op_reg;
    logic             out_drew_reg, out_sound_reg, out_wait_reg, out_bad_reg;
    logic [7:0]       out_dbyte_reg;
    logic             out_load;

    // memory, register file and stack ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              fb_we;
    logic [FB_AW-1:0]  fb_addr;
    logic [7:0]        fb_wdata, fb_rdata;
    logic              v_we;
    logic [3:0]        v_waddr, v_raddr;
    logic [7:0]        v_wdata, v_rdata;
    logic              stk_we;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    // decode helpers
    logic [3:0]  opc, fx, fy, fn;
    logic [7:0]  fnn;
    logic [11:0] fnnn, pc_plus2, pc_plus4, i_plus_cnt;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [3:0]  key_hi;
    logic [12:0] i_sum;
    logic [1:0]  bcd_h;
    logic [3:0]  bcd_t, bcd_o;
    logic [13:0] bcd_p1;
    logic [14:0] bcd_p2;
    logic [7:0]  bcd_r;
    logic [2:0]  bx0, bx1;
    logic [15:0] draw_mask;
    logic [4:0]  draw_y;
    logic        pressed;

    vmc8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    vmc8_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_fb (
        .clk   (clk),
        .we    (fb_we),
        .addr  (fb_addr),
        .wdata (fb_wdata),
        .rdata (fb_rdata)
    );

    vmc8_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign opc        = op_reg[15:12];
    assign fx         = op_reg[11:8];
    assign fy         = op_reg[7:4];
    assign fn         = op_reg[3:0];
    assign fnn        = op_reg[7:0];
    assign fnnn       = op_reg[11:0];
    assign pc_plus2   = pc_reg + 12'd2;
    assign pc_plus4   = pc_reg + 12'd4;
    assign i_plus_cnt = i_reg + {8'd0, cnt_reg[3:0]};
    assign sp_inc     = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec     = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign i_sum      = {1'b0, i_reg} + {5'd0, vx_reg};
    assign v_rdata    = v_reg[v_raddr];
    assign pressed    = keys_reg[vx_reg[3:0]];

    // highest pressed key
    always_comb
    begin
        key_hi = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (keys_reg[k])
                key_hi = 4'(k);
        end
    end

    // decimal digits of VX by reciprocal multiply (exact for 8-bit values)
    always_comb
    begin
        bcd_p1 = {6'd0, vx_reg} * 14'd41;
        bcd_h  = bcd_p1[13:12];
        bcd_r  = vx_reg - 8'({6'd0, bcd_h} * 8'd100);
        bcd_p2 = {7'd0, bcd_r} * 15'd205;
        bcd_t  = bcd_p2[14:11];
        bcd_o  = 4'(bcd_r - 8'({4'd0, bcd_t} * 8'd10));
    end

    // sprite row placement: one row spans two adjacent frame buffer bytes
    assign bx0       = vx_reg[5:3];
    assign bx1       = bx0 + 3'd1;
    assign draw_mask = {sprite_reg, 8'd0} >> vx_reg[2:0];
    assign draw_y    = vy_reg[4:0] + {1'b0, row_reg};

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        keys_next   = keys_reg;
        rnd_next    = rnd_reg;
        pc_next     = pc_reg;
        i_next      = i_reg;
        sp_next     = sp_reg;
        delay_next  = delay_reg;
        sound_next  = sound_reg;
        op_next     = op_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        flag_next   = flag_reg;
        hit_next    = hit_reg;
        sprite_next = sprite_reg;
        row_next    = row_reg;
        drew_next   = drew_reg;
        wait_next   = wait_reg;
        bad_next    = bad_reg;
        dbyte_next  = dbyte_reg;
        out_valid_next = out_valid_reg && out_stall;

        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = 8'd0;
        fb_we     = 1'b0;
        fb_addr   = '0;
        fb_wdata  = 8'd0;
        v_we      = 1'b0;
        v_waddr   = fx;
        v_wdata   = alu_rsp.res;
        v_raddr   = 4'd0;
        stk_we    = 1'b0;
        alu_req   = '{op: ALU_PASS, a: 8'd0, b: 8'd0};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg[MEM_AW-1:0];
                mem_wdata = font_byte(cnt_reg);
                fb_we     = (cnt_reg < CNT_W'(FB_BYTES));
                fb_addr   = cnt_reg[FB_AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MEMORY_BYTES - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    addr_next  = address;
                    data_next  = data;
                    keys_next  = keys;
                    rnd_next   = random_byte;
                    op_next    = 16'd0;
                    drew_next  = 1'b0;
                    wait_next  = 1'b0;
                    bad_next   = 1'b0;
                    dbyte_next = 8'd0;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                unique case (mode_reg)
                    MODE_LOAD:
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = mem_index(addr_reg);
                        mem_wdata  = data_reg;
                        state_next = S_DONE;
                    end
                    MODE_EXEC:
                    begin
                        mem_addr   = mem_index(pc_reg);
                        state_next = S_F1;
                    end
                    MODE_READ:
                    begin
                        fb_addr    = addr_reg[FB_AW-1:0];
                        state_next = S_RD;
                    end
                    MODE_NONE:
                        state_next = S_DONE;
                endcase
            end

            S_RD:
            begin
                dbyte_next = fb_rdata;
                state_next = S_DONE;
            end

            S_F1:
            begin
                op_next[15:8] = mem_rdata;
                mem_addr      = mem_index(pc_reg + 12'd1);
                state_next    = S_F2;
            end

            S_F2:
            begin
                op_next[7:0] = mem_rdata;
                state_next   = S_VX;
            end

            S_VX:
            begin
                v_raddr    = fx;
                vx_next    = v_rdata;
                state_next = S_VY;
            end

            S_VY:
            begin
                v_raddr    = (opc == OPC_JPV0) ? 4'd0 : fy;
                vy_next    = v_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                pc_next    = pc_plus2;
                state_next = S_TICK;
                unique case (opc)
                    OPC_SYS:
                    begin
                        if (op_reg == OP_CLS)
                        begin
                            drew_next  = 1'b1;
                            cnt_next   = '0;
                            state_next = S_CLS;
                        end
                        else if (op_reg == OP_RET)
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec] + 12'd2;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    OPC_JP:
                        pc_next = fnnn;
                    OPC_CALL:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = fnnn;
                    end
                    OPC_SEI:
                        pc_next = (vx_reg == fnn) ? pc_plus4 : pc_plus2;
                    OPC_SNEI:
                        pc_next = (vx_reg != fnn) ? pc_plus4 : pc_plus2;
                    OPC_SER:
                    begin
                        if (fn != 4'd0)
                            bad_next = 1'b1;
                        else
                            pc_next = (vx_reg == vy_reg) ? pc_plus4 : pc_plus2;
                    end
                    OPC_SNER:
                    begin
                        if (fn != 4'd0)
                            bad_next = 1'b1;
                        else
                            pc_next = (vx_reg != vy_reg) ? pc_plus4 : pc_plus2;
                    end
                    OPC_LDI:
                    begin
                        alu_req = '{op: ALU_PASS, a: vx_reg, b: fnn};
                        v_we    = 1'b1;
                    end
                    OPC_ADDI:
                    begin
                        alu_req = '{op: ALU_ADD, a: vx_reg, b: fnn};
                        v_we    = 1'b1;
                    end
                    OPC_ALU:
                    begin
                        v_we      = 1'b1;
                        flag_next = alu_rsp.flag;
                        unique case (fn)
                            AOP_LD:  alu_req = '{op: ALU_PASS, a: vx_reg, b: vy_reg};
                            AOP_OR:  alu_req = '{op: ALU_OR, a: vx_reg, b: vy_reg};
                            AOP_AND: alu_req = '{op: ALU_AND, a: vx_reg, b: vy_reg};
                            AOP_XOR: alu_req = '{op: ALU_XOR, a: vx_reg, b: vy_reg};
                            AOP_ADD:
                            begin
                                alu_req    = '{op: ALU_ADD, a: vx_reg, b: vy_reg};
                                state_next = S_WRF;
                            end
                            AOP_SUB:
                            begin
                                alu_req    = '{op: ALU_SUB, a: vx_reg, b: vy_reg};
                                state_next = S_WRF;
                            end
                            AOP_SHR:
                            begin
                                alu_req    = '{op: ALU_SHR, a: vx_reg, b: vy_reg};
                                state_next = S_WRF;
                            end
                            AOP_SUBN:
                            begin
                                alu_req    = '{op: ALU_SUB, a: vy_reg, b: vx_reg};
                                state_next = S_WRF;
                            end
                            AOP_SHL:
                            begin
                                alu_req    = '{op: ALU_SHL, a: vx_reg, b: vy_reg};
                                state_next = S_WRF;
                            end
                            default:
                            begin
                                v_we     = 1'b0;
                                bad_next = 1'b1;
                            end
                        endcase
                    end
                    OPC_LDIX:
                        i_next = fnnn;
                    OPC_JPV0:
                        pc_next = fnnn + {4'd0, vy_reg};
                    OPC_RND:
                    begin
                        alu_req = '{op: ALU_AND, a: rnd_reg, b: fnn};
                        v_we    = 1'b1;
                    end
                    OPC_DRW:
                    begin
                        drew_next  = 1'b1;
                        hit_next   = 1'b0;
                        row_next   = 4'd0;
                        state_next = (fn == 4'd0) ? S_DVF : S_DMEM;
                    end
                    OPC_KEY:
                    begin
                        if (fnn == KEY_DOWN)
                            pc_next = pressed ? pc_plus4 : pc_plus2;
                        else if (fnn == KEY_UP)
                            pc_next = pressed ? pc_plus2 : pc_plus4;
                        else
                            bad_next = 1'b1;
                    end
                    OPC_MISC:
                    begin
                        unique case (fnn)
                            FOP_GDT:
                            begin
                                alu_req = '{op: ALU_PASS, a: vx_reg, b: delay_reg};
                                v_we    = 1'b1;
                            end
                            FOP_WKEY:
                            begin
                                if (keys_reg == 16'd0)
                                begin
                                    wait_next = 1'b1;
                                    pc_next   = pc_reg;
                                end
                                else
                                begin
                                    alu_req = '{op: ALU_PASS, a: vx_reg, b: {4'd0, key_hi}};
                                    v_we    = 1'b1;
                                end
                            end
                            FOP_SDT:
                                delay_next = vx_reg;
                            FOP_SST:
                                sound_next = vx_reg;
                            FOP_ADDI:
                            begin
                                i_next  = i_sum[11:0];
                                alu_req = '{op: ALU_PASS, a: vx_reg, b: {7'd0, i_sum[12]}};
                                v_waddr = REG_F;
                                v_we    = 1'b1;
                            end
                            FOP_FONT:
                                i_next = {6'd0, vx_reg[3:0], 2'd0} + {8'd0, vx_reg[3:0]};
                            FOP_BCD:
                            begin
                                mem_we     = 1'b1;
                                mem_addr   = mem_index(i_reg);
                                mem_wdata  = {6'd0, bcd_h};
                                state_next = S_BCD1;
                            end
                            FOP_STOR:
                            begin
                                cnt_next   = '0;
                                state_next = S_SVR;
                            end
                            FOP_LOAD:
                            begin
                                cnt_next   = '0;
                                state_next = S_LMR;
                            end
                            default:
                                bad_next = 1'b1;
                        endcase
                    end
                endcase
            end

            S_WRF:
            begin
                v_we       = 1'b1;
                v_waddr    = REG_F;
                v_wdata    = {7'd0, flag_reg};
                state_next = S_TICK;
            end

            S_CLS:
            begin
                fb_we    = 1'b1;
                fb_addr  = cnt_reg[FB_AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FB_BYTES - 1))
                    state_next = S_TICK;
            end

            S_DMEM:
            begin
                mem_addr   = mem_index(i_reg + {8'd0, row_reg});
                state_next = S_DFB0R;
            end

            S_DFB0R:
            begin
                sprite_next = mem_rdata;
                fb_addr     = {draw_y, bx0};
                state_next  = S_DFB0W;
            end

            S_DFB0W:
            begin
                fb_we      = 1'b1;
                fb_addr    = {draw_y, bx0};
                fb_wdata   = fb_rdata ^ draw_mask[15:8];
                hit_next   = hit_reg | (|(fb_rdata & draw_mask[15:8]));
                state_next = S_DFB1R;
            end

            S_DFB1R:
            begin
                fb_addr    = {draw_y, bx1};
                state_next = S_DFB1W;
            end

            S_DFB1W:
            begin
                fb_we    = 1'b1;
                fb_addr  = {draw_y, bx1};
                fb_wdata = fb_rdata ^ draw_mask[7:0];
                hit_next = hit_reg | (|(fb_rdata & draw_mask[7:0]));
                row_next = row_reg + 4'd1;
                if (row_reg == fn - 4'd1)
                    state_next = S_DVF;
                else
                    state_next = S_DMEM;
            end

            S_DVF:
            begin
                v_we       = 1'b1;
                v_waddr    = REG_F;
                v_wdata    = {7'd0, hit_reg};
                state_next = S_TICK;
            end

            S_BCD1:
            begin
                mem_we     = 1'b1;
                mem_addr   = mem_index(i_reg + 12'd1);
                mem_wdata  = {4'd0, bcd_t};
                state_next = S_BCD2;
            end

            S_BCD2:
            begin
                mem_we     = 1'b1;
                mem_addr   = mem_index(i_reg + 12'd2);
                mem_wdata  = {4'd0, bcd_o};
                state_next = S_TICK;
            end

            S_SVR:
            begin
                v_raddr    = cnt_reg[3:0];
                vy_next    = v_rdata;
                state_next = S_SMW;
            end

            S_SMW:
            begin
                mem_we    = 1'b1;
                mem_addr  = mem_index(i_plus_cnt);
                mem_wdata = vy_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[3:0] == fx)
                begin
                    i_next     = i_plus_cnt + 12'd1;
                    state_next = S_TICK;
                end
                else
                    state_next = S_SVR;
            end

            S_LMR:
            begin
                mem_addr   = mem_index(i_plus_cnt);
                state_next = S_LVW;
            end

            S_LVW:
            begin
                v_we     = 1'b1;
                v_waddr  = cnt_reg[3:0];
                v_wdata  = mem_rdata;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[3:0] == fx)
                begin
                    i_next     = i_plus_cnt + 12'd1;
                    state_next = S_TICK;
                end
                else
                    state_next = S_LMR;
            end

            S_TICK:
            begin
                if (delay_reg != 8'd0)
                    delay_next = delay_reg - 8'd1;
                if (sound_reg != 8'd0)
                    sound_next = sound_reg - 8'd1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pc_reg        <= 12'(PROGRAM_START);
            i_reg         <= 12'd0;
            sp_reg        <= '0;
            delay_reg     <= 8'd0;
            sound_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
                v_reg[k] <= 8'd0;
            for (int k = 0; k < STACK_DEPTH; k++)
                stack_reg[k] <= 12'd0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            out_valid_reg <= out_valid_next;
            if (v_we)
                v_reg[v_waddr] <= v_wdata;
            if (stk_we)
                stack_reg[sp_reg] <= pc_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        keys_reg   <= keys_next;
        rnd_reg    <= rnd_next;
        op_reg     <= op_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        flag_reg   <= flag_next;
        hit_reg    <= hit_next;
        sprite_reg <= sprite_next;
        row_reg    <= row_next;
        drew_reg   <= drew_next;
        wait_reg   <= wait_next;
        bad_reg    <= bad_next;
        dbyte_reg  <= dbyte_next;
        if (out_load)
        begin
            out_pc_reg    <= pc_reg;
            out_op_reg    <= op_reg;
            out_drew_reg  <= drew_reg;
            out_sound_reg <= (sound_reg != 8'd0);
            out_wait_reg  <= wait_reg;
            out_bad_reg   <= bad_reg;
            out_dbyte_reg <= dbyte_reg;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign program_counter = out_pc_reg;
    assign executed_opcode = out_op_reg;
    assign display_changed = out_drew_reg;
    assign sound_on        = out_sound_reg;
    assign waiting_for_key = out_wait_reg;
    assign invalid_opcode  = out_bad_reg;
    assign display_byte    = out_dbyte_reg;

endmodule

// ----- hdl/vmc8_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module vmc8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            store[addr] <= wdata;
        rdata <= store[addr];
    end

endmodule

// ----- hdl/vmc8_alu.sv -----
// Shared 8-bit ALU that feeds the register writes made in the execute state.
`timescale 1ns / 1ps

module vmc8_alu import vmc8_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [8:0] sum;

    always_comb
    begin
        sum = {1'b0, req.a} + {1'b0, req.b};
        rsp = '{res: req.b, flag: 1'b0};
        unique case (req.op)
            ALU_PASS: rsp = '{res: req.b, flag: 1'b0};
            ALU_OR:   rsp = '{res: req.a | req.b, flag: 1'b0};
            ALU_AND:  rsp = '{res: req.a & req.b, flag: 1'b0};
            ALU_XOR:  rsp = '{res: req.a ^ req.b, flag: 1'b0};
            ALU_ADD:  rsp = '{res: sum[7:0], flag: sum[8]};
            ALU_SUB:  rsp = '{res: req.a - req.b, flag: (req.a >= req.b)};
            ALU_SHR:  rsp = '{res: {1'b0, req.a[7:1]}, flag: req.a[0]};
            ALU_SHL:  rsp = '{res: {req.a[6:0], 1'b0}, flag: req.a[7]};
        endcase
    end

endmodule

// ----- hdl/vmc8_chk.sv -----
// Port-level checker for the interpreter core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vmc8_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] executed_opcode,
    input logic [11:0] program_counter,
    input logic        display_changed,
    input logic        waiting_for_key,
    input logic        invalid_opcode,
    input logic [7:0]  display_byte
);

    // a result word held under stall keeps its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(program_counter) && $stable(executed_opcode), "result word changed under stall")

    // one word at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

    // lit display pixels only come back from a read word
    `ASSERT_IMPLY(a_read_result, clk, rst_n, out_valid && display_byte != 8'd0, executed_opcode == 16'd0 && !display_changed && !invalid_opcode, "display byte on a non-read word")

    // key wait only from FX0A and never together with a draw or an invalid opcode
    `ASSERT_IMPLY(a_key_wait, clk, rst_n, out_valid && waiting_for_key, executed_opcode[15:12] == 4'hF && executed_opcode[7:0] == 8'h0A && !display_changed && !invalid_opcode, "key wait flag on wrong word")

endmodule

bind vm_core_8bit_sixteen_register vmc8_chk u_vmc8_chk (.*);
